@@ design/complex_arith_unit_core_macros.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITH_UNIT_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_arith_unit_core: implication check failed");

// next-cycle implication, checked through reset as well
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("complex_arith_unit_core: next-cycle check failed");

`endif

@@ design/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes, item types and the saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int DW  = 16;
  localparam int FB  = 8;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int MW  = SW - 1;
  localparam int RW  = PW + DW;
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);
  localparam int QCW = QAW + 1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]           op;
    logic                 dz;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } item_t;

  typedef struct packed {
    logic          ovf;
    logic [DW-1:0] val;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [SW-1:0] v);
    sat_t                 r;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi    = SW'(SAT_MAX);
    lo    = SW'(SAT_MIN);
    r.ovf = 1'b0;
    r.val = v[DW-1:0];
    if (v > hi) begin
      r.ovf = 1'b1;
      r.val = SAT_MAX;
    end else if (v < lo) begin
      r.ovf = 1'b1;
      r.val = SAT_MIN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/cau_front.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts command items, flags zero-denominator divides and feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire  [1:0]                 in_req_type,
  input  wire  signed [cau_pkg::DW-1:0] in_a_re,
  input  wire  signed [cau_pkg::DW-1:0] in_a_im,
  input  wire  signed [cau_pkg::DW-1:0] in_b_re,
  input  wire  signed [cau_pkg::DW-1:0] in_b_im,
  input  wire                        q_full,
  output logic                       push,
  output cau_pkg::item_t             push_item
);
  import cau_pkg::*;

  logic  front_v_r;
  logic  front_v_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign busy      = front_v_r && q_full;
  assign accept    = start && !busy;
  assign push      = front_v_r && !q_full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.op   = in_req_type;
    item_nxt.dz   = (in_req_type == OP_DIV) && (in_b_re == '0) && (in_b_im == '0);
    item_nxt.a_re = in_a_re;
    item_nxt.a_im = in_a_im;
    item_nxt.b_re = in_b_re;
    item_nxt.b_im = in_b_im;
    front_v_nxt   = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (push) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/cau_queue.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit item queue
// Short FIFO between front end and datapath; drains one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  cau_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  output cau_pkg::item_t pop_item
);
  import cau_pkg::*;

  item_t          mem_r [QD];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QCW-1:0] cnt_r;
  logic [QCW-1:0] cnt_nxt;

  assign full      = (cnt_r == QCW'(QD));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_valid ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ design/cau_back.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit datapath
// Products, combine, restoring divide pipeline and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  cau_pkg::item_t          in_item,
  output logic                    out_valid,
  output logic [cau_pkg::DW-1:0]  out_res_re,
  output logic [cau_pkg::DW-1:0]  out_res_im,
  output logic                    out_overflow,
  output logic                    out_div_zero
);
  import cau_pkg::*;

  typedef struct packed {
    logic          dz;
    logic          div;
    sat_t          nd_re;
    sat_t          nd_im;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [PW-1:0] den;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [DW-1:0] q_re;
    logic [DW-1:0] q_im;
  } stage_t;

  // product stage
  logic                 p_v_r;
  logic [1:0]           p_op_r;
  logic                 p_dz_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [PW-1:0]        p_br2_r, p_bi2_r;
  logic signed [DW:0]   p_sre_r, p_sim_r;
  logic signed [DW:0]   p_sre_nxt, p_sim_nxt;

  always_comb begin
    if (in_item.op == OP_SUB) begin
      p_sre_nxt = (DW+1)'(in_item.a_re) - (DW+1)'(in_item.b_re);
      p_sim_nxt = (DW+1)'(in_item.a_im) - (DW+1)'(in_item.b_im);
    end else begin
      p_sre_nxt = (DW+1)'(in_item.a_re) + (DW+1)'(in_item.b_re);
      p_sim_nxt = (DW+1)'(in_item.a_im) + (DW+1)'(in_item.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_op_r  <= in_item.op;
    p_dz_r  <= in_item.dz;
    p_rr_r  <= PW'(in_item.a_re) * PW'(in_item.b_re);
    p_ii_r  <= PW'(in_item.a_im) * PW'(in_item.b_im);
    p_ri_r  <= PW'(in_item.a_re) * PW'(in_item.b_im);
    p_ir_r  <= PW'(in_item.a_im) * PW'(in_item.b_re);
    p_br2_r <= $unsigned(PW'(in_item.b_re) * PW'(in_item.b_re));
    p_bi2_r <= $unsigned(PW'(in_item.b_im) * PW'(in_item.b_im));
    p_sre_r <= p_sre_nxt;
    p_sim_r <= p_sim_nxt;
  end

  // combine stage
  logic                 c_v_r;
  logic [1:0]           c_op_r;
  logic                 c_dz_r;
  sat_t                 c_nd_re_r, c_nd_im_r;
  sat_t                 c_nd_re_nxt, c_nd_im_nxt;
  logic signed [SW-1:0] c_num_re_r, c_num_im_r;
  logic [PW-1:0]        c_den_r;
  logic signed [SW-1:0] mul_re, mul_im;

  always_comb begin
    mul_re = (SW'(p_rr_r) - SW'(p_ii_r)) >>> FB;
    mul_im = (SW'(p_ri_r) + SW'(p_ir_r)) >>> FB;
    if (p_op_r == OP_ADD || p_op_r == OP_SUB) begin
      c_nd_re_nxt = sat_wide(SW'(p_sre_r));
      c_nd_im_nxt = sat_wide(SW'(p_sim_r));
    end else begin
      c_nd_re_nxt = sat_wide(mul_re);
      c_nd_im_nxt = sat_wide(mul_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c_op_r     <= p_op_r;
    c_dz_r     <= p_dz_r;
    c_nd_re_r  <= c_nd_re_nxt;
    c_nd_im_r  <= c_nd_im_nxt;
    c_num_re_r <= SW'(p_rr_r) + SW'(p_ii_r);
    c_num_im_r <= SW'(p_ir_r) - SW'(p_ri_r);
    c_den_r    <= p_br2_r + p_bi2_r;
  end

  // divide setup and quotient stages
  stage_t               st_r [DW+1];
  logic                 sv_r [DW+1];
  stage_t               st0_nxt;
  logic signed [SW-1:0] mre_w, mim_w;
  logic [RW-1:0]        n_re, n_im, den_top;

  always_comb begin
    st0_nxt.dz     = c_dz_r;
    st0_nxt.div    = (c_op_r == OP_DIV);
    st0_nxt.nd_re  = c_nd_re_r;
    st0_nxt.nd_im  = c_nd_im_r;
    st0_nxt.neg_re = c_num_re_r[SW-1];
    st0_nxt.neg_im = c_num_im_r[SW-1];
    mre_w          = c_num_re_r[SW-1] ? -c_num_re_r : c_num_re_r;
    mim_w          = c_num_im_r[SW-1] ? -c_num_im_r : c_num_im_r;
    n_re           = RW'(mre_w[MW-1:0]) << FB;
    n_im           = RW'(mim_w[MW-1:0]) << FB;
    den_top        = RW'(c_den_r) << DW;
    st0_nxt.big_re = (n_re >= den_top);
    st0_nxt.big_im = (n_im >= den_top);
    st0_nxt.den    = c_den_r;
    st0_nxt.rem_re = n_re;
    st0_nxt.rem_im = n_im;
    st0_nxt.q_re   = '0;
    st0_nxt.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  for (genvar k = 1; k <= DW; k++) begin : g_div
    stage_t        st_nxt;
    logic [RW-1:0] dsh;

    always_comb begin
      st_nxt = st_r[k-1];
      dsh    = RW'(st_r[k-1].den) << (DW - k);
      if (st_r[k-1].rem_re >= dsh) begin
        st_nxt.rem_re       = st_r[k-1].rem_re - dsh;
        st_nxt.q_re[DW - k] = 1'b1;
      end
      if (st_r[k-1].rem_im >= dsh) begin
        st_nxt.rem_im       = st_r[k-1].rem_im - dsh;
        st_nxt.q_im[DW - k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else begin
        sv_r[k] <= sv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
  end

  // result stage
  logic          out_v_r;
  sat_t          res_re_r, res_im_r;
  logic          dz_r;
  sat_t          res_re_nxt, res_im_nxt;
  sat_t          dq_re, dq_im;
  stage_t        fin;

  function automatic sat_t div_sat(input logic neg, input logic big,
                                   input logic [DW-1:0] q);
    sat_t r;
    r.ovf = 1'b0;
    r.val = neg ? -q : q;
    if (neg && (big || q > SAT_MIN)) begin
      r.ovf = 1'b1;
      r.val = SAT_MIN;
    end else if (!neg && (big || q[DW-1])) begin
      r.ovf = 1'b1;
      r.val = SAT_MAX;
    end
    return r;
  endfunction

  always_comb begin
    fin   = st_r[DW];
    dq_re = div_sat(fin.neg_re, fin.big_re, fin.q_re);
    dq_im = div_sat(fin.neg_im, fin.big_im, fin.q_im);
    if (!fin.div) begin
      res_re_nxt = fin.nd_re;
      res_im_nxt = fin.nd_im;
    end else if (fin.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
    end else begin
      res_re_nxt = dq_re;
      res_im_nxt = dq_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= sv_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    dz_r     <= fin.div && fin.dz;
  end

  assign out_valid    = out_v_r;
  assign out_res_re   = res_re_r.val;
  assign out_res_im   = res_im_r.val;
  assign out_overflow = res_re_r.ovf | res_im_r.ovf;
  assign out_div_zero = dz_r;

endmodule

`default_nettype wire

@@ design/complex_arith_unit_core.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide of two signed Q8.8 complex operands.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_req_type and the four operand parts with start high; the item
//   is taken at a rising edge where busy is low. Operations: add, subtract,
//   multiply, divide.
//   Each result shows for one cycle with out_valid high: real and imaginary
//   parts saturated to 16 bits, out_overflow when either part saturated and
//   out_div_zero for a divide by zero (parts zero).
//   Every operation passes through the same pipeline stages from acceptance
//   to the result edge, so results leave in order. One item per cycle is
//   sustained: the divide is a 16-stage restoring pipeline, one quotient bit
//   per stage, and the multipliers are fully pipelined.
//   A four-entry queue sits between the input register and the datapath;
//   busy rises only if that queue fills, which the free-running datapath
//   never lets happen.
//   Reset clears all valid flags; no result is shown after reset until a
//   new item comes through. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [1:0]                    in_req_type,
  input  wire  signed [cau_pkg::DW-1:0] in_a_re,
  input  wire  signed [cau_pkg::DW-1:0] in_a_im,
  input  wire  signed [cau_pkg::DW-1:0] in_b_re,
  input  wire  signed [cau_pkg::DW-1:0] in_b_im,
  output logic                          out_valid,
  output logic [cau_pkg::DW-1:0]        out_res_re,
  output logic [cau_pkg::DW-1:0]        out_res_im,
  output logic                          out_overflow,
  output logic                          out_div_zero
);
  import cau_pkg::*;

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop_valid;
  item_t pop_item;

  cau_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  cau_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pop_valid),
    .in_item      (pop_item),
    .out_valid    (out_valid),
    .out_res_re   (out_res_re),
    .out_res_im   (out_res_im),
    .out_overflow (out_overflow),
    .out_div_zero (out_div_zero)
  );

endmodule

`default_nettype wire

@@ design/cau_checker.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit port checker
// Port-level checks on flags, saturation and reset, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arith_unit_core_macros.svh"

module cau_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           start,
  input wire                           busy,
  input wire                           out_valid,
  input wire [cau_pkg::DW-1:0]         out_res_re,
  input wire [cau_pkg::DW-1:0]         out_res_im,
  input wire                           out_overflow,
  input wire                           out_div_zero
);
  import cau_pkg::*;

  `CAU_ASSERT_IMP(a_dz_zero, out_valid && out_div_zero, out_res_re == '0 && out_res_im == '0 && !out_overflow)
  `CAU_ASSERT_IMP(a_ovf_limit, out_valid && out_overflow, out_res_re == SAT_MAX || out_res_re == SAT_MIN || out_res_im == SAT_MAX || out_res_im == SAT_MIN)
  `CAU_ASSERT_NXT(a_rst_quiet, !rst_n, !busy && !out_valid)
  `CAU_ASSERT_IMP(a_never_busy, start, !busy)

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_res_re   (out_res_re),
  .out_res_im   (out_res_im),
  .out_overflow (out_overflow),
  .out_div_zero (out_div_zero)
);

`default_nettype wire
